/* hw/rtl/interval_heap_double_ended_queue_assert.svh */
// Assertion macros for the interval heap queue RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef INTERVAL_HEAP_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define INTERVAL_HEAP_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define IHQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval heap queue: same-cycle check failed");
// Next-cycle implication.
`define IHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval heap queue: next-cycle check failed");
`else
`define IHQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/ihq_pkg.sv */
`default_nettype none
package ihq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int NODES    = (CAPACITY + 1) / 2;
    localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REM_MIN = 2'd1;
    localparam logic [1:0] CMD_REM_MAX = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [NODE_AW-1:0]      idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef struct packed {
        logic [1:0] command;
        key_t       value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        key_t       removed_value;
        key_t       current_min;
        key_t       current_max;
        cnt_t       element_total;
        logic       is_empty;
        logic       is_full;
    } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/interval_heap_double_ended_queue.sv */
`default_nettype none
// Double-ended priority queue of signed 32-bit keys, stored as an interval heap.
// The cmd channel carries one beat per command: insert a key, remove the
// minimum, or remove the maximum. The rsp channel returns exactly one beat per
// command with the status, the removed key, the new minimum and maximum, the key
// count and the empty and full flags. Both channels use valid and stall.
// Commands are taken one at a time: cmd_stall is high from the beat that is
// accepted until that command's result has moved into the response register.
// An insert climbs the tree twice, for the min end and then the max end; a removal
// descends it once, each step bound by the single read port of each node
// memory. With 512 nodes the tree has ten levels. Once a result reaches the
// response register, the next command can be accepted in the cycle after that.
// A finished result waits in the response register while rsp_stall is high, and
// the next command is accepted meanwhile; its result is held inside until the
// register frees.
// Reset empties the queue at once; the node memories are not cleared.
module interval_heap_double_ended_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire ihq_pkg::in_item_t  cmd_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ihq_pkg::out_item_t      rsp_data
);
    import ihq_pkg::*;

    logic      ctl_idle;
    logic      res_valid;
    logic      res_ready;
    out_item_t res;
    logic      rsp_valid_reg, rsp_valid_next;
    out_item_t rsp_data_reg;

    // The controller only starts a command from idle, so stall is its busy flag.
    assign cmd_stall = !ctl_idle;

    ihq_ctl u_ctl (
        .clk(clk),
        .rst_n(rst_n),
        .start(cmd_valid && ctl_idle),
        .item(cmd_data),
        .idle(ctl_idle),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    // The response register frees when it is empty or its beat is taken.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`include "interval_heap_double_ended_queue_assert.svh"

    // An accepted command always keeps the controller busy for the next cycle.
    `IHQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)
    // The key count never passes the capacity.
    `IHQ_ASSERT_IMPLY(a_count_bound, clk, rst_n, rsp_valid, rsp_data.element_total <= cnt_t'(CAPACITY))
    // The empty flag agrees with the count.
    `IHQ_ASSERT_IMPLY(a_empty_flag, clk, rst_n, rsp_valid, rsp_data.is_empty == (rsp_data.element_total == '0))
    // A dropped insert only happens on a full queue and removes nothing.
    `IHQ_ASSERT_IMPLY(a_full_drop, clk, rst_n, rsp_valid && rsp_data.status == STAT_FULL, rsp_data.is_full && rsp_data.removed_value == '0)

endmodule
`default_nettype wire

/* hw/rtl/ihq_ram.sv */
`default_nettype none
module ihq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ihq_ctl.sv */
`default_nettype none
module ihq_ctl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ihq_pkg::in_item_t  item,
    output logic                    idle,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ihq_pkg::out_item_t      res
);
    import ihq_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INS_LD  = 5'd1;
    localparam logic [4:0] S_UPMIN_R = 5'd2;
    localparam logic [4:0] S_UPMIN_D = 5'd3;
    localparam logic [4:0] S_UPMAX_L = 5'd4;
    localparam logic [4:0] S_UPMAX_X = 5'd5;
    localparam logic [4:0] S_UPMAX_R = 5'd6;
    localparam logic [4:0] S_UPMAX_D = 5'd7;
    localparam logic [4:0] S_REM1    = 5'd8;
    localparam logic [4:0] S_REM2    = 5'd9;
    localparam logic [4:0] S_DMIN_H  = 5'd10;
    localparam logic [4:0] S_DMIN_A  = 5'd11;
    localparam logic [4:0] S_DMIN_B  = 5'd12;
    localparam logic [4:0] S_DMAX_H  = 5'd13;
    localparam logic [4:0] S_DMAX_A  = 5'd14;
    localparam logic [4:0] S_DMAX_C  = 5'd15;
    localparam logic [4:0] S_DMAX_D  = 5'd16;
    localparam logic [4:0] S_FIN     = 5'd17;
    localparam logic [4:0] S_RES     = 5'd18;

    logic [4:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    idx_t       i_reg, i_next;
    key_t       x_reg, x_next;
    key_t       tmp_reg, tmp_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [1:0] status_reg, status_next;
    key_t       removed_reg, removed_next;

    logic              lo_we, hi_we, lo_re, hi_re;
    idx_t              lo_wa, hi_wa, lo_ra, hi_ra;
    logic [KEY_W-1:0]  lo_wd, hi_wd, lo_rdata, hi_rdata;
    key_t              q_lo, q_hi;

    idx_t par_idx, c_idx, c1_idx, last_idx;
    cnt_t child_w, child1_w, m_w;
    logic full_i, full_c, full_c1;
    logic is_min;

    ihq_ram #(.DATA_W(KEY_W), .DEPTH(NODES)) u_low (
        .clk(clk), .we(lo_we), .waddr(lo_wa), .wdata(lo_wd),
        .re(lo_re), .raddr(lo_ra), .rdata(lo_rdata)
    );

    ihq_ram #(.DATA_W(KEY_W), .DEPTH(NODES)) u_high (
        .clk(clk), .we(hi_we), .waddr(hi_wa), .wdata(hi_wd),
        .re(hi_re), .raddr(hi_ra), .rdata(hi_rdata)
    );

    assign q_lo = lo_rdata;
    assign q_hi = hi_rdata;

    // Heap index arithmetic for the node under work.
    assign par_idx  = (i_reg - idx_t'(1)) >> 1;
    assign child_w  = cnt_t'({i_reg, 1'b1});
    assign child1_w = child_w + cnt_t'(1);
    assign c_idx    = child_w[NODE_AW-1:0];
    assign c1_idx   = child1_w[NODE_AW-1:0];
    assign m_w      = (cnt_reg + cnt_t'(1)) >> 1;
    assign last_idx = NODE_AW'((cnt_reg - cnt_t'(1)) >> 1);
    assign full_i   = child_w < cnt_reg;
    assign full_c   = cnt_t'({c_idx, 1'b1}) < cnt_reg;
    assign full_c1  = cnt_t'({c1_idx, 1'b1}) < cnt_reg;
    assign is_min   = (cmd_reg == CMD_REM_MIN);

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        key_t xs;
        key_t cand;
        idx_t ci;
        logic swap;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        x_next       = x_reg;
        tmp_next     = tmp_reg;
        cmd_next     = cmd_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        lo_we = 1'b0; lo_wa = i_reg; lo_wd = x_reg;
        hi_we = 1'b0; hi_wa = i_reg; hi_wd = x_reg;
        lo_re = 1'b0; lo_ra = i_reg;
        hi_re = 1'b0; hi_ra = i_reg;
        res_valid = 1'b0;
        xs   = x_reg;
        cand = tmp_reg;
        ci   = c_idx;
        swap = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = item.command;
                    x_next       = item.value;
                    status_next  = STAT_OK;
                    removed_next = '0;
                    case (item.command)
                        CMD_INSERT:
                        begin
                            if (cnt_reg >= cnt_t'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + cnt_t'(1);
                                i_next   = NODE_AW'(cnt_reg >> 1);
                                if (cnt_reg[0])
                                begin
                                    lo_re      = 1'b1;
                                    lo_ra      = NODE_AW'(cnt_reg >> 1);
                                    state_next = S_INS_LD;
                                end
                                else
                                begin
                                    state_next = S_UPMIN_R;
                                end
                            end
                        end
                        CMD_REM_MIN, CMD_REM_MAX:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                lo_re      = 1'b1;
                                hi_re      = 1'b1;
                                lo_ra      = '0;
                                hi_ra      = '0;
                                state_next = S_REM1;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_LD:
            begin
                // The last node gains its second key; order the pair.
                hi_we = 1'b1;
                if (x_reg < q_lo)
                begin
                    hi_wd = q_lo;
                end
                else
                begin
                    hi_wd  = x_reg;
                    x_next = q_lo;
                end
                state_next = S_UPMIN_R;
            end
            S_UPMIN_R:
            begin
                if (i_reg == '0)
                begin
                    lo_we      = 1'b1;
                    state_next = S_UPMAX_L;
                end
                else
                begin
                    lo_re      = 1'b1;
                    lo_ra      = par_idx;
                    state_next = S_UPMIN_D;
                end
            end
            S_UPMIN_D:
            begin
                lo_we = 1'b1;
                if (x_reg < q_lo)
                begin
                    lo_wd      = q_lo;
                    i_next     = par_idx;
                    state_next = S_UPMIN_R;
                end
                else
                begin
                    state_next = S_UPMAX_L;
                end
            end
            S_UPMAX_L:
            begin
                i_next     = last_idx;
                lo_re      = 1'b1;
                hi_re      = 1'b1;
                lo_ra      = last_idx;
                hi_ra      = last_idx;
                state_next = S_UPMAX_X;
            end
            S_UPMAX_X:
            begin
                x_next     = full_i ? q_hi : q_lo;
                state_next = S_UPMAX_R;
            end
            S_UPMAX_R:
            begin
                if (i_reg == '0)
                begin
                    hi_we      = full_i;
                    lo_we      = !full_i;
                    state_next = S_FIN;
                end
                else
                begin
                    hi_re      = 1'b1;
                    hi_ra      = par_idx;
                    state_next = S_UPMAX_D;
                end
            end
            S_UPMAX_D:
            begin
                hi_we = full_i;
                lo_we = !full_i;
                if (x_reg > q_hi)
                begin
                    hi_wd      = q_hi;
                    lo_wd      = q_hi;
                    i_next     = par_idx;
                    state_next = S_UPMAX_R;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_REM1:
            begin
                removed_next = (is_min || cnt_reg == cnt_t'(1)) ? q_lo : q_hi;
                tmp_next     = q_hi;
                lo_re        = 1'b1;
                hi_re        = 1'b1;
                lo_ra        = last_idx;
                hi_ra        = last_idx;
                state_next   = S_REM2;
            end
            S_REM2:
            begin
                if (cnt_reg == cnt_t'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
                else if (cnt_reg == cnt_t'(2))
                begin
                    cnt_next = cnt_t'(1);
                    if (is_min)
                    begin
                        lo_we = 1'b1;
                        lo_wa = '0;
                        lo_wd = tmp_reg;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - cnt_t'(1);
                    i_next   = '0;
                    x_next   = (cnt_reg[0] || is_min) ? q_lo : q_hi;
                    if (is_min && !cnt_reg[0])
                    begin
                        lo_we = 1'b1;
                        lo_wa = last_idx;
                        lo_wd = q_hi;
                    end
                    state_next = is_min ? S_DMIN_H : S_DMAX_H;
                end
            end
            S_DMIN_H:
            begin
                hi_re      = 1'b1;
                hi_ra      = i_reg;
                lo_re      = 1'b1;
                lo_ra      = c_idx;
                state_next = S_DMIN_A;
            end
            S_DMIN_A:
            begin
                swap   = full_i && (x_reg > q_hi);
                xs     = swap ? q_hi : x_reg;
                hi_we  = swap;
                x_next = xs;
                if (!(child_w < m_w))
                begin
                    lo_we      = 1'b1;
                    lo_wd      = xs;
                    state_next = S_FIN;
                end
                else if (child1_w < m_w)
                begin
                    tmp_next   = q_lo;
                    lo_re      = 1'b1;
                    lo_ra      = c1_idx;
                    state_next = S_DMIN_B;
                end
                else
                begin
                    lo_we = 1'b1;
                    if (q_lo >= xs)
                    begin
                        lo_wd      = xs;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        lo_wd      = q_lo;
                        i_next     = c_idx;
                        state_next = S_DMIN_H;
                    end
                end
            end
            S_DMIN_B:
            begin
                if (q_lo < tmp_reg)
                begin
                    cand = q_lo;
                    ci   = c1_idx;
                end
                lo_we = 1'b1;
                if (cand >= x_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lo_wd      = cand;
                    i_next     = ci;
                    state_next = S_DMIN_H;
                end
            end
            S_DMAX_H:
            begin
                lo_re      = 1'b1;
                lo_ra      = i_reg;
                state_next = S_DMAX_A;
            end
            S_DMAX_A:
            begin
                swap   = full_i && (x_reg < q_lo);
                xs     = swap ? q_lo : x_reg;
                lo_we  = swap;
                x_next = xs;
                if (!(child_w < m_w))
                begin
                    // Settle here: the max end, or the single key of a half-full node, takes the carried key.
                    if (full_i)
                    begin
                        hi_we = 1'b1;
                        hi_wd = xs;
                    end
                    else
                    begin
                        lo_we = 1'b1;
                        lo_wd = xs;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    lo_re      = 1'b1;
                    hi_re      = 1'b1;
                    lo_ra      = c_idx;
                    hi_ra      = c_idx;
                    state_next = S_DMAX_C;
                end
            end
            S_DMAX_C:
            begin
                cand     = full_c ? q_hi : q_lo;
                tmp_next = cand;
                if (child1_w < m_w)
                begin
                    lo_re      = 1'b1;
                    hi_re      = 1'b1;
                    lo_ra      = c1_idx;
                    hi_ra      = c1_idx;
                    state_next = S_DMAX_D;
                end
                else if (cand <= x_reg)
                begin
                    hi_we      = full_i;
                    lo_we      = !full_i;
                    state_next = S_FIN;
                end
                else
                begin
                    hi_we      = 1'b1;
                    hi_wd      = cand;
                    i_next     = c_idx;
                    state_next = S_DMAX_H;
                end
            end
            S_DMAX_D:
            begin
                if ((full_c1 ? q_hi : q_lo) > tmp_reg)
                begin
                    cand = full_c1 ? q_hi : q_lo;
                    ci   = c1_idx;
                end
                if (cand <= x_reg)
                begin
                    hi_we      = full_i;
                    lo_we      = !full_i;
                    state_next = S_FIN;
                end
                else
                begin
                    hi_we      = 1'b1;
                    hi_wd      = cand;
                    i_next     = ci;
                    state_next = S_DMAX_H;
                end
            end
            S_FIN:
            begin
                lo_re      = 1'b1;
                hi_re      = 1'b1;
                lo_ra      = '0;
                hi_ra      = '0;
                state_next = S_RES;
            end
            S_RES:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The root pair read in S_FIN stays on the read ports until the next read.
    always_comb
    begin
        res.status        = status_reg;
        res.removed_value = removed_reg;
        res.element_total = cnt_reg;
        res.is_empty      = (cnt_reg == '0);
        res.is_full       = (cnt_reg >= cnt_t'(CAPACITY));
        res.current_min   = (cnt_reg == '0) ? key_t'(0) : q_lo;
        if (cnt_reg == '0)
        begin
            res.current_max = '0;
        end
        else if (cnt_reg == cnt_t'(1))
        begin
            res.current_max = q_lo;
        end
        else
        begin
            res.current_max = q_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        x_reg       <= x_next;
        tmp_reg     <= tmp_next;
        cmd_reg     <= cmd_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

endmodule
`default_nettype wire
